// ===== design/bpfc_pkg.sv =====
// Package for the BGRA pixel format converter.
// Holds the beat structs, format codes, queue entry type and byte constants.
// No dependencies.
`timescale 1ns / 1ps

package bpfc_pkg;

  typedef enum logic [2:0] {
    FMT_BGRX32     = 3'd0,
    FMT_RGBX32     = 3'd1,
    FMT_PACKED24   = 3'd2,
    FMT_RGB444_PAD = 3'd3,
    FMT_RGB565_PAD = 3'd4,
    FMT_RGB565     = 3'd5
  } fmt_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_in_row;
    logic       last_in_frame;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       row_end;
    logic       frame_end;
    logic       bad_format;
  } pix_out_t;

  // One classified pixel: data bytes, then zero padding up to n_total.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n_data;
    logic [2:0]      n_total;
    logic            row;
    logic            frame;
    logic            bad;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] PAD_BYTE     = 8'h00;

endpackage

// ===== design/bpfc_front.sv =====
// Front end of the pixel converter: format register, row byte phase,
// per-pixel byte build and padding count. Depends on bpfc_pkg.
`timescale 1ns / 1ps

module bpfc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_data,
  input  logic             take,
  input  bpfc_pkg::pix_in_t pix,
  output bpfc_pkg::desc_t  desc
);

  logic [2:0] fmt_r, fmt_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [11:0] w444;
  logic [15:0] w565;
  logic [1:0] ph_sum;
  logic [1:0] pads;
  logic       padded;
  logic       row;

  assign row  = pix.last_in_row | pix.last_in_frame;
  assign w444 = {pix.red[7:4], pix.green[7:4], pix.blue[7:4]};
  assign w565 = {pix.red[7:3], pix.green[7:2], pix.blue[7:3]};

  always_comb begin
    desc        = '0;
    desc.row    = row;
    desc.frame  = pix.last_in_frame;
    padded      = 1'b0;
    case (fmt_r)
      bpfc_pkg::FMT_BGRX32: begin
        desc.bytes  = {bpfc_pkg::ALPHA_OPAQUE, pix.red, pix.green, pix.blue};
        desc.n_data = 3'd4;
      end
      bpfc_pkg::FMT_RGBX32: begin
        desc.bytes  = {bpfc_pkg::ALPHA_OPAQUE, pix.blue, pix.green, pix.red};
        desc.n_data = 3'd4;
      end
      bpfc_pkg::FMT_PACKED24: begin
        desc.bytes  = {bpfc_pkg::PAD_BYTE, pix.red, pix.green, pix.blue};
        desc.n_data = 3'd3;
        padded      = 1'b1;
      end
      bpfc_pkg::FMT_RGB444_PAD: begin
        desc.bytes  = {16'h0000, 4'h0, w444};
        desc.n_data = 3'd2;
        padded      = 1'b1;
      end
      bpfc_pkg::FMT_RGB565_PAD: begin
        desc.bytes  = {16'h0000, w565};
        desc.n_data = 3'd2;
        padded      = 1'b1;
      end
      bpfc_pkg::FMT_RGB565: begin
        desc.bytes  = {16'h0000, w565};
        desc.n_data = 3'd2;
      end
      default: begin
        desc.bad    = 1'b1;
        desc.n_data = 3'd1;
      end
    endcase
    ph_sum = phase_r + desc.n_data[1:0];
    pads   = (row && padded) ? (2'd0 - ph_sum) : 2'd0;
    if (desc.bad) begin
      desc.n_total = 3'd1;
    end else begin
      desc.n_total = desc.n_data + {1'b0, pads};
    end
  end

  always_comb begin
    fmt_nxt   = cfg_we ? cfg_data : fmt_r;
    phase_nxt = phase_r;
    if (take) begin
      if (row) begin
        phase_nxt = 2'd0;
      end else if (!desc.bad) begin
        phase_nxt = ph_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= bpfc_pkg::FMT_BGRX32;
      phase_r <= 2'd0;
    end else begin
      fmt_r   <= fmt_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== design/bpfc_queue.sv =====
// Two-entry queue of classified pixels between front and back end.
// Depends on bpfc_pkg.
`timescale 1ns / 1ps

module bpfc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bpfc_pkg::desc_t    wdata,
  input  logic               pop,
  output bpfc_pkg::desc_t    rdata,
  output bpfc_pkg::q_stat_t  stat
);

  bpfc_pkg::desc_t mem_r [bpfc_pkg::QDEPTH];
  logic [bpfc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bpfc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bpfc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == bpfc_pkg::QCNT_W'(bpfc_pkg::QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bpfc_pkg::QPTR_W'(bpfc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bpfc_pkg::QPTR_W'(bpfc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/bpfc_back.sv =====
// Back end of the pixel converter: walks the queue head one byte per beat
// into a registered output stage. Depends on bpfc_pkg.
`timescale 1ns / 1ps

module bpfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  bpfc_pkg::desc_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output bpfc_pkg::pix_out_t out_data
);

  logic [2:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  bpfc_pkg::pix_out_t od_r, od_nxt;
  logic       adv, emit, last;

  assign adv   = !ov_r || out_ready;
  assign emit  = adv && q_valid;
  assign last  = (idx_r == q_data.n_total - 3'd1);
  assign q_pop = emit && last;

  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;
    if (adv) begin
      ov_nxt = q_valid;
    end
    if (emit) begin
      idx_nxt             = last ? 3'd0 : idx_r + 3'd1;
      od_nxt.out_byte     = (idx_r < q_data.n_data) ? q_data.bytes[idx_r[1:0]]
                                                    : bpfc_pkg::PAD_BYTE;
      od_nxt.last_of_item = last;
      od_nxt.row_end      = last && q_data.row;
      od_nxt.frame_end    = last && q_data.frame;
      od_nxt.bad_format   = q_data.bad;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== design/bgra_pixel_format_converter.sv =====
// Top level of the BGRA pixel format converter.
// Instantiates bpfc_front, bpfc_queue and bpfc_back; depends on bpfc_pkg.
//
// Usage:
//   in_*  : one BGRA source pixel per beat (valid/ready), with row and
//           frame end marks.
//   out_* : one destination byte per beat (valid/ready), in memory order.
//   cfg_* : cfg_we writes the 3-bit format register (reset 0, 32-bit BGRX);
//           write only while the block is idle.
// Each pixel yields one to six bytes: four in the 32-bit formats, three or
// two in the packed ones, plus zero padding at row end in padded formats.
// The back end emits one byte per cycle while the output is not stalled, and
// pops the queue head when its last byte enters the registered output stage.
// An accepted pixel goes through a queue entry and then the output register.
// A two-entry queue sits between the classifier and the serializer, so
// the input keeps taking pixels while the output stalls until the queue
// fills. Synchronous reset empties the queue and output stage and clears
// the row byte phase and format register.
`timescale 1ns / 1ps

module bgra_pixel_format_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpfc_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bpfc_pkg::pix_out_t out_data
);

  bpfc_pkg::desc_t   f_desc;
  bpfc_pkg::desc_t   q_data;
  bpfc_pkg::q_stat_t q_stat;
  logic              take;
  logic              q_pop;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  bpfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .take     (take),
    .pix      (in_data),
    .desc     (f_desc)
  );

  bpfc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .wdata (f_desc),
    .pop   (q_pop),
    .rdata (q_data),
    .stat  (q_stat)
  );

  bpfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_stat.valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_take_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> q_stat.valid)
    else $error("accepted pixel not visible in queue");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_format) |->
      (out_data.last_of_item && out_data.out_byte == bpfc_pkg::PAD_BYTE))
    else $error("bad format beat malformed");

  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frame_end) |-> out_data.row_end)
    else $error("frame end without row end");

  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.row_end) |-> out_data.last_of_item)
    else $error("row end on non-final byte");

endmodule
